[hw/rtl/irc_pkg.sv]
// ----------------------------------------------------------------------------
// irc_pkg: shared types and constants of the IRC format code parser
// Control byte codes, parse phases, request and result records, and the
// record pair that travels from the front end to the result side.
// ----------------------------------------------------------------------------
`default_nettype none

package irc_pkg;

  localparam int COLUMN_BITS_DEF = 10;
  localparam int MAXC_W          = 10;
  localparam int CFG_DATA_W      = 10;
  localparam int CFG_INDEX_W     = 2;
  localparam int QDEPTH          = 4;

  localparam logic [CFG_INDEX_W-1:0] CFG_COLOUR_EN = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_COLS  = 2'd1;

  localparam logic [MAXC_W-1:0] MAX_COLS_RESET = 10'd80;

  localparam logic [7:0] BYTE_BOLD      = 8'h02;
  localparam logic [7:0] BYTE_COLOUR    = 8'h03;
  localparam logic [7:0] BYTE_RESET     = 8'h0F;
  localparam logic [7:0] BYTE_REVERSE   = 8'h16;
  localparam logic [7:0] BYTE_ITALIC    = 8'h1D;
  localparam logic [7:0] BYTE_UNDERLINE = 8'h1F;
  localparam logic [7:0] BYTE_SPACE     = 8'd32;
  localparam logic [7:0] BYTE_COMMA     = 8'h2C;
  localparam logic [7:0] BYTE_ZERO      = 8'h30;
  localparam logic [7:0] BYTE_NINE      = 8'h39;

  typedef enum logic [5:0] {
    PH_TEXT    = 6'b000001,
    PH_CTRL    = 6'b000010,
    PH_FG_ONE  = 6'b000100,
    PH_FG_DONE = 6'b001000,
    PH_COMMA   = 6'b010000,
    PH_BG_ONE  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       line_last;
  } in_t;

  typedef struct packed {
    logic       shown_valid;
    logic [7:0] shown_byte;
    logic       char_start;
    logic       bold_on;
    logic       underline_on;
    logic       italic_on;
    logic       reverse_on;
    logic       fg_valid;
    logic [3:0] fg_index;
    logic       line_end;
    logic       run_last;
  } out_t;

  // one or two results caused by a single request
  typedef struct packed {
    logic two;
    out_t r0;
    out_t r1;
  } pair_t;

  typedef struct packed {
    logic  head_valid;
    pair_t head;
  } qhead_t;

endpackage

`default_nettype wire

[hw/rtl/irc_front.sv]
// ----------------------------------------------------------------------------
// irc_front: request classifier and line state
// Takes one byte per request, updates the attribute and parse state, and
// pushes the one or two results it causes, if any, as a pair into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module irc_front
  import irc_pkg::*;
#(
  parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   byte_valid,
  output logic                        byte_stall,
  input  wire in_t                    byte_item,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   q_full,
  output logic                        q_push,
  output pair_t                       q_data
);

  localparam int CMP_W = (COLUMN_BITS > MAXC_W) ? COLUMN_BITS : MAXC_W;

  typedef struct packed {
    logic                   bold;
    logic                   underline;
    logic                   italic;
    logic                   reverse;
    logic                   cset;
    logic [3:0]             cidx;
    phase_t                 ph;
    logic [6:0]             acc;
    logic [1:0]             cont;
    logic [COLUMN_BITS-1:0] cnt;
  } st_t;

  typedef struct packed {
    st_t  s;
    logic hit;
    out_t r;
  } tstep_t;

  typedef struct packed {
    logic [1:0] n;
    out_t       r0;
    out_t       r1;
  } res_t;

  logic              colour_en;
  logic [MAXC_W-1:0] max_cols;
  st_t               st;
  st_t               st_next;
  res_t              res;
  logic              accept;

  function automatic st_t clear_state();
    st_t s;
    s = '0;
    s.ph = PH_TEXT;
    return s;
  endfunction

  function automatic out_t mk(st_t s, logic [7:0] b, logic start);
    out_t r;
    r              = '0;
    r.shown_valid  = 1'b1;
    r.shown_byte   = b;
    r.char_start   = start;
    r.bold_on      = s.bold;
    r.underline_on = s.underline;
    r.italic_on    = s.italic;
    r.reverse_on   = s.reverse;
    r.fg_valid     = s.cset;
    r.fg_index     = s.cset ? s.cidx : 4'd0;
    return r;
  endfunction

  function automatic tstep_t text_in(st_t s, logic [7:0] b, logic [MAXC_W-1:0] maxc);
    tstep_t t;
    logic [1:0] len_m1;
    t     = '0;
    t.s   = s;
    len_m1 = 2'd0;
    if (CMP_W'(s.cnt) < CMP_W'(maxc)) begin
      case (b)
        BYTE_BOLD:      t.s.bold      = ~s.bold;
        BYTE_UNDERLINE: t.s.underline = ~s.underline;
        BYTE_ITALIC:    t.s.italic    = ~s.italic;
        BYTE_REVERSE:   t.s.reverse   = ~s.reverse;
        BYTE_RESET: begin
          t.s.bold      = 1'b0;
          t.s.underline = 1'b0;
          t.s.italic    = 1'b0;
          t.s.reverse   = 1'b0;
          t.s.cset      = 1'b0;
          t.s.cidx      = 4'd0;
        end
        BYTE_COLOUR: begin
          t.s.ph  = PH_CTRL;
          t.s.acc = 7'd0;
        end
        default: begin
          if (b >= BYTE_SPACE) begin
            // UTF-8 lead byte sets how many continuation bytes pass through
            if (b[7] == 1'b0)             len_m1 = 2'd0;
            else if (b[7:5] == 3'b110)    len_m1 = 2'd1;
            else if (b[7:4] == 4'b1110)   len_m1 = 2'd2;
            else if (b[7:3] == 5'b11110)  len_m1 = 2'd3;
            else                          len_m1 = 2'd0;
            t.hit    = 1'b1;
            t.r      = mk(s, b, 1'b1);
            t.s.cont = len_m1;
            if (s.cnt != {COLUMN_BITS{1'b1}}) begin
              t.s.cnt = s.cnt + 1'b1;
            end
          end
        end
      endcase
    end
    return t;
  endfunction

  function automatic res_t push(res_t a, tstep_t t);
    res_t o;
    o = a;
    if (t.hit) begin
      if (a.n == 2'd0) o.r0 = t.r;
      else             o.r1 = t.r;
      o.n = a.n + 2'd1;
    end
    return o;
  endfunction

  function automatic st_t apply_fg(st_t s, logic present, logic cen);
    st_t o;
    o = s;
    if (!present) begin
      o.cset = 1'b0;
      o.cidx = 4'd0;
    end else if (cen) begin
      o.cset = 1'b1;
      o.cidx = s.acc[3:0];
    end
    return o;
  endfunction

  always_comb begin
    st_t        s;
    tstep_t     t;
    res_t       a;
    logic [7:0] b;
    logic       digit;
    s     = st;
    t     = '0;
    a     = '0;
    b     = byte_item.text_byte;
    digit = (b >= BYTE_ZERO) && (b <= BYTE_NINE);
    if (s.cont != 2'd0) begin
      t     = '0;
      t.hit = 1'b1;
      t.r   = mk(s, b, 1'b0);
      a     = push(a, t);
      s.cont = s.cont - 2'd1;
    end else begin
      case (s.ph)
        PH_TEXT: begin
          t = text_in(s, b, max_cols);
          s = t.s;
          a = push(a, t);
        end
        PH_CTRL, PH_FG_ONE: begin
          if (digit) begin
            if (s.ph == PH_CTRL) begin
              s.acc = {3'b000, b[3:0]};
              s.ph  = PH_FG_ONE;
            end else begin
              s.acc = (s.acc << 3) + (s.acc << 1) + {3'b000, b[3:0]};
              s     = apply_fg(s, 1'b1, colour_en);
              s.ph  = PH_FG_DONE;
            end
          end else begin
            s = apply_fg(s, s.ph == PH_FG_ONE, colour_en);
            if (b == BYTE_COMMA) begin
              s.ph = PH_COMMA;
            end else begin
              s.ph = PH_TEXT;
              t = text_in(s, b, max_cols);
              s = t.s;
              a = push(a, t);
            end
          end
        end
        PH_FG_DONE: begin
          if (b == BYTE_COMMA) begin
            s.ph = PH_COMMA;
          end else begin
            s.ph = PH_TEXT;
            t = text_in(s, b, max_cols);
            s = t.s;
            a = push(a, t);
          end
        end
        PH_COMMA: begin
          if (digit) begin
            s.ph = PH_BG_ONE;
          end else begin
            // bare comma is text, then the byte after it
            s.ph = PH_TEXT;
            t = text_in(s, BYTE_COMMA, max_cols);
            s = t.s;
            a = push(a, t);
            t = text_in(s, b, max_cols);
            s = t.s;
            a = push(a, t);
          end
        end
        PH_BG_ONE: begin
          s.ph = PH_TEXT;
          if (!digit) begin
            t = text_in(s, b, max_cols);
            s = t.s;
            a = push(a, t);
          end
        end
        default: begin
          s.ph = PH_TEXT;
          t = text_in(s, b, max_cols);
          s = t.s;
          a = push(a, t);
        end
      endcase
    end
    if (byte_item.line_last) begin
      if (s.ph == PH_COMMA) begin
        s.ph = PH_TEXT;
        t = text_in(s, BYTE_COMMA, max_cols);
        s = t.s;
        a = push(a, t);
      end
      if (a.n == 2'd0) begin
        // marker result for a line whose last byte shows nothing
        a.r0 = '0;
        a.n  = 2'd1;
      end
      if (a.n == 2'd2) a.r1.line_end = 1'b1;
      else             a.r0.line_end = 1'b1;
      s = clear_state();
    end
    if (a.n == 2'd2)      a.r1.run_last = 1'b1;
    else if (a.n != 2'd0) a.r0.run_last = 1'b1;
    st_next = s;
    res     = a;
  end

  assign byte_stall = q_full;
  assign accept     = byte_valid && !q_full;
  assign q_push     = accept && (res.n != 2'd0);
  assign q_data     = '{two: (res.n == 2'd2), r0: res.r0, r1: res.r1};

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= clear_state();
      colour_en <= 1'b1;
      max_cols  <= MAX_COLS_RESET;
    end else begin
      if (accept) begin
        st <= st_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_COLOUR_EN: colour_en <= cfg_data[0];
          CFG_MAX_COLS:  max_cols  <= cfg_data[MAXC_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/irc_fifo.sv]
// ----------------------------------------------------------------------------
// irc_fifo: result pair queue
// Short queue between the front end and the result side so that each can
// stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module irc_fifo
  import irc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire pair_t push_data,
  input  wire logic  pop,
  output logic       full,
  output qhead_t     head
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  pair_t            mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full   = (count == CNT_W'(QDEPTH));
  assign do_pop = pop && (count != '0);
  assign head   = '{head_valid: (count != '0), head: mem[rd_ptr]};

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/irc_emit.sv]
// ----------------------------------------------------------------------------
// irc_emit: result sequencer
// Hands out the results of the head pair one at a time and pops the pair
// once its last result has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module irc_emit
  import irc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire qhead_t head,
  output logic        pop,
  output logic        res_valid,
  input  wire logic   res_stall,
  output out_t        res_item
);

  logic sub;
  logic taken;

  assign res_valid = head.head_valid;
  assign res_item  = sub ? head.head.r1 : head.head.r0;
  assign taken     = res_valid && !res_stall;
  assign pop       = taken && (sub || !head.head.two);

  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= 1'b0;
    end else if (taken) begin
      // advance to the second result, or back to the first on pop
      sub <= !pop;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/irc_format_code_parser_top.sv]
// ----------------------------------------------------------------------------
// irc_format_code_parser_top: IRC formatting code parser
// Turns raw chat line bytes into displayable bytes tagged with attributes.
// ----------------------------------------------------------------------------
// One byte request is taken per clock while the four-entry result queue has
// room; its first result can be taken on the next clock. The result side
// delivers one result per clock while res_stall is low, so a byte that causes
// two results (a bare comma shown together with the following character)
// holds the port until both are taken, and the result port sets the sustained
// rate: one request per clock when each causes at most one result, otherwise
// one result per clock. Configuration writes take effect on the next clock.
`default_nettype none

module irc_format_code_parser_top
  import irc_pkg::*;
#(
  parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   byte_valid,
  output logic                        byte_stall,
  input  wire in_t                    byte_item,
  output logic                        res_valid,
  input  wire logic                   res_stall,
  output out_t                        res_item,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic   q_full;
  logic   q_push;
  pair_t  q_data;
  logic   q_pop;
  qhead_t q_head;

  irc_front #(
    .COLUMN_BITS(COLUMN_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_data)
  );

  irc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .full      (q_full),
    .head      (q_head)
  );

  irc_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .pop       (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  a_marker_at_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_item.shown_valid |-> res_item.line_end && res_item.run_last)
    else $error("result without a byte outside line end");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.line_end |-> res_item.run_last)
    else $error("line end not on the last result of its request");

  a_full_has_output: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> res_valid)
    else $error("requests stalled with no result pending");

  a_default_colour: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_item.fg_valid |-> res_item.fg_index == 4'd0)
    else $error("colour index set without a foreground colour");

endmodule

`default_nettype wire

[tb/irc_format_checker.sv]
// ----------------------------------------------------------------------------
// irc_format_checker: result checker for the IRC format code parser
// Watches the byte, result and register ports. It keeps its own model of the
// attribute and colour state, works out the results of every accepted request
// and compares each accepted result, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module irc_format_checker
  import irc_pkg::*;
#(
  parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   byte_valid,
  input  wire logic                   byte_stall,
  input  wire in_t                    byte_item,
  input  wire logic                   res_valid,
  input  wire logic                   res_stall,
  input  wire out_t                   res_item,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output int                          mismatches,
  output int                          results_due,
  output int                          results_checked
);

  // register copies
  logic                   colour_en_q;
  logic [MAXC_W-1:0]      max_cols_q;

  // per-line parse state
  logic                   bold_q;
  logic                   uline_q;
  logic                   ital_q;
  logic                   rev_q;
  logic                   fg_set_q;
  logic [3:0]             fg_idx_q;
  phase_t                 phase_q;
  logic [6:0]             digits_q;
  logic [1:0]             cont_q;
  logic [COLUMN_BITS-1:0] cols_q;

  out_t                   step_out [2];
  int                     step_n;
  out_t                   shown_due [$];
  int                     fail_q;
  int                     seen_q;

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    fail_q++;
  endtask

  task automatic clear_line();
    bold_q   = 1'b0;
    uline_q  = 1'b0;
    ital_q   = 1'b0;
    rev_q    = 1'b0;
    fg_set_q = 1'b0;
    fg_idx_q = '0;
    phase_q  = PH_TEXT;
    digits_q = '0;
    cont_q   = '0;
    cols_q   = '0;
  endtask

  task automatic show(input logic [7:0] b, input logic first);
    out_t r;
    if (step_n < 2) begin
      r              = '0;
      r.shown_valid  = 1'b1;
      r.shown_byte   = b;
      r.char_start   = first;
      r.bold_on      = bold_q;
      r.underline_on = uline_q;
      r.italic_on    = ital_q;
      r.reverse_on   = rev_q;
      r.fg_valid     = fg_set_q;
      r.fg_index     = fg_set_q ? fg_idx_q : 4'd0;
      step_out[step_n] = r;
      step_n++;
    end
  endtask

  // no digits clears the colour; digits only count while colour is enabled
  task automatic set_fg(input logic present);
    if (!present) begin
      fg_set_q = 1'b0;
      fg_idx_q = '0;
    end else if (colour_en_q) begin
      fg_set_q = 1'b1;
      fg_idx_q = digits_q[3:0];
    end
  endtask

  task automatic take_text(input logic [7:0] b);
    logic [1:0] extra;
    extra = '0;
    if (COLUMN_BITS'(cols_q) >= max_cols_q) return;
    case (b)
      BYTE_BOLD:      bold_q  = ~bold_q;
      BYTE_UNDERLINE: uline_q = ~uline_q;
      BYTE_ITALIC:    ital_q  = ~ital_q;
      BYTE_REVERSE:   rev_q   = ~rev_q;
      BYTE_RESET: begin
        bold_q   = 1'b0;
        uline_q  = 1'b0;
        ital_q   = 1'b0;
        rev_q    = 1'b0;
        fg_set_q = 1'b0;
        fg_idx_q = '0;
      end
      BYTE_COLOUR: begin
        phase_q  = PH_CTRL;
        digits_q = '0;
      end
      default: begin
        if (b >= BYTE_SPACE) begin
          // UTF-8 lead bytes let the rest of the character through
          if (b[7:5] == 3'b110) extra = 2'd1;
          else if (b[7:4] == 4'b1110) extra = 2'd2;
          else if (b[7:3] == 5'b11110) extra = 2'd3;
          show(b, 1'b1);
          cont_q = extra;
          if (cols_q != '1) cols_q = cols_q + 1'b1;
        end
      end
    endcase
  endtask

  task automatic parse_byte(input in_t req);
    logic [7:0] b;
    logic       is_dig;
    logic [6:0] d;
    int         k;
    b      = req.text_byte;
    is_dig = (b >= BYTE_ZERO) && (b <= BYTE_NINE);
    d      = 7'(b - BYTE_ZERO);
    step_n = 0;
    if (cont_q != 2'd0) begin
      show(b, 1'b0);
      cont_q = cont_q - 1'b1;
    end else begin
      case (phase_q)
        PH_TEXT: take_text(b);
        PH_CTRL, PH_FG_ONE: begin
          if (is_dig) begin
            if (phase_q == PH_CTRL) begin
              digits_q = d;
              phase_q  = PH_FG_ONE;
            end else begin
              digits_q = 7'(digits_q * 7'd10 + d);
              set_fg(1'b1);
              phase_q = PH_FG_DONE;
            end
          end else begin
            set_fg(phase_q == PH_FG_ONE);
            if (b == BYTE_COMMA) begin
              phase_q = PH_COMMA;
            end else begin
              phase_q = PH_TEXT;
              take_text(b);
            end
          end
        end
        PH_FG_DONE: begin
          if (b == BYTE_COMMA) begin
            phase_q = PH_COMMA;
          end else begin
            phase_q = PH_TEXT;
            take_text(b);
          end
        end
        PH_COMMA: begin
          if (is_dig) begin
            phase_q = PH_BG_ONE;
          end else begin
            // a comma without a background digit is plain text
            phase_q = PH_TEXT;
            take_text(BYTE_COMMA);
            take_text(b);
          end
        end
        PH_BG_ONE: begin
          phase_q = PH_TEXT;
          if (!is_dig) take_text(b);
        end
        default: begin
          phase_q = PH_TEXT;
          take_text(b);
        end
      endcase
    end

    if (req.line_last) begin
      if (phase_q == PH_COMMA) begin
        phase_q = PH_TEXT;
        take_text(BYTE_COMMA);
      end
      // an empty line end still gives one marker result
      if (step_n == 0) begin
        step_out[0] = '0;
        step_n      = 1;
      end
      step_out[step_n - 1].line_end = 1'b1;
      clear_line();
    end
    if (step_n > 0) step_out[step_n - 1].run_last = 1'b1;
    for (k = 0; k < step_n; k++) shown_due = {shown_due, step_out[k]};
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report($sformatf("result %0d: %s is %0h, expected %0h", seen_q, name, got, want));
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (shown_due.size() == 0) begin
      report($sformatf("result %0d arrived with nothing due (%h)", seen_q, got));
    end else begin
      want = shown_due.pop_front();
      check_field("shown_valid", got.shown_valid, want.shown_valid);
      check_field("shown_byte", got.shown_byte, want.shown_byte);
      check_field("char_start", got.char_start, want.char_start);
      check_field("bold_on", got.bold_on, want.bold_on);
      check_field("underline_on", got.underline_on, want.underline_on);
      check_field("italic_on", got.italic_on, want.italic_on);
      check_field("reverse_on", got.reverse_on, want.reverse_on);
      check_field("fg_valid", got.fg_valid, want.fg_valid);
      check_field("fg_index", got.fg_index, want.fg_index);
      check_field("line_end", got.line_end, want.line_end);
      check_field("run_last", got.run_last, want.run_last);
    end
    seen_q++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      colour_en_q = 1'b1;
      max_cols_q  = MAX_COLS_RESET;
      clear_line();
      shown_due.delete();
    end else begin
      if (res_valid && !res_stall) check_result(res_item);
      if (byte_valid && !byte_stall) parse_byte(byte_item);
      // a register write counts from the next request on
      if (cfg_we) begin
        if (cfg_index == CFG_COLOUR_EN) colour_en_q = cfg_data[0];
        else if (cfg_index == CFG_MAX_COLS) max_cols_q = cfg_data[MAXC_W-1:0];
      end
    end
    mismatches      <= fail_q;
    results_due     <= shown_due.size();
    results_checked <= seen_q;
  end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for the IRC format code parser
// Feeds a directed line of control codes, colour codes and UTF-8 characters,
// then random well-formed and broken lines under several register settings,
// with random sender gaps and result stalls, and a long result hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import irc_pkg::*;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PRESSURE
  } rx_mode_t;

  localparam int IDLE_LIMIT  = 3000;
  localparam int SETTLE_WAIT = 8;
  localparam int END_WAIT    = 20;

  localparam logic [7:0] ATTR_CODES [5] = '{BYTE_BOLD, BYTE_UNDERLINE, BYTE_ITALIC,
                                            BYTE_REVERSE, BYTE_RESET};

  logic                   clk        = 1'b0;
  logic                   rst        = 1'b1;
  logic                   byte_valid = 1'b0;
  logic                   byte_stall;
  in_t                    byte_item  = '0;
  logic                   res_valid;
  logic                   res_stall  = 1'b0;
  out_t                   res_item;
  logic                   cfg_we     = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  int         mismatches;
  int         results_due;
  int         results_checked;

  rx_mode_t   rx_mode       = STALL_NONE;
  logic       sender_calm   = 1'b0;
  int         burst_left    = 0;
  int         sent_in_phase = 0;
  int         settings_run  = 0;
  int         requests_taken = 0;
  int         idle_cycles   = 0;
  int         rx_cycle      = 0;
  logic [7:0] line_bytes [$];

  irc_format_code_parser_top dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  irc_format_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .byte_valid      (byte_valid),
    .byte_stall      (byte_stall),
    .byte_item       (byte_item),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .res_item        (res_item),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .results_due     (results_due),
    .results_checked (results_checked)
  );

  always #2 clk = ~clk;

  // result side: stall pattern per mode; pressure mode adds a periodic hold-off to random stalls
  always @(posedge clk) begin
    rx_cycle++;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      case (rx_mode)
        STALL_NONE:     res_stall <= 1'b0;
        STALL_LIGHT:    res_stall <= ($urandom_range(0, 9) < 2);
        STALL_HEAVY:    res_stall <= ($urandom_range(0, 9) < 6);
        STALL_PRESSURE: res_stall <= ((rx_cycle % 160) < 70) || ($urandom_range(0, 9) < 2);
        default:        res_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && byte_valid && !byte_stall) requests_taken <= requests_taken + 1;
    if (rst || (byte_valid && !byte_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (sender_calm) gap = 0;
      else if ($urandom_range(0, 3) == 0) gap = $urandom_range(5, 25);
      else gap = $urandom_range(0, 3);
      if (gap > 0) begin
        byte_valid <= 1'b0;
        byte_item  <= in_t'(9'($urandom));
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    byte_valid <= 1'b1;
    byte_item  <= '{text_byte: b, line_last: last};
    do @(posedge clk); while (byte_stall);
    sent_in_phase++;
  endtask

  task automatic send_line();
    int i;
    for (i = 0; i < line_bytes.size(); i++)
      send_byte(line_bytes[i], i == line_bytes.size() - 1);
  endtask

  task automatic add_byte(input logic [7:0] v);
    line_bytes = {line_bytes, v};
  endtask

  task automatic build_line();
    int         tokens;
    int         k;
    int         n;
    int         j;
    int         len;
    logic [7:0] r;
    line_bytes.delete();
    tokens = $urandom_range(1, 10);
    for (k = 0; k < tokens; k++) begin
      n = $urandom_range(0, 99);
      r = 8'($urandom);
      if (n < 40) begin
        add_byte(8'($urandom_range(32, 126)));
      end else if (n < 52) begin
        add_byte(ATTR_CODES[$urandom_range(0, 4)]);
      end else if (n < 74) begin
        add_byte(BYTE_COLOUR);
        repeat ($urandom_range(0, 2)) add_byte(8'(BYTE_ZERO + $urandom_range(0, 9)));
        if ($urandom_range(0, 1) == 1) begin
          add_byte(BYTE_COMMA);
          repeat ($urandom_range(0, 2))
            add_byte(8'(BYTE_ZERO + $urandom_range(0, 9)));
        end
      end else if (n < 86) begin
        len = $urandom_range(2, 4);
        case (len)
          2:       add_byte({3'b110, r[4:0]});
          3:       add_byte({4'b1110, r[3:0]});
          default: add_byte({5'b11110, r[2:0]});
        endcase
        for (j = 1; j < len; j++) begin
          if ($urandom_range(0, 5) == 0) add_byte(8'($urandom));
          else add_byte({2'b10, 6'($urandom)});
        end
      end else begin
        add_byte(r);
      end
    end
    // cut some lines short to break a sequence at the line end
    if ($urandom_range(0, 7) == 0 && line_bytes.size() > 1) begin
      j = $urandom_range(1, line_bytes.size() - 1);
      repeat (j) r = line_bytes.pop_back();
    end
  endtask

  task automatic run_lines(input int count);
    while (sent_in_phase < count) begin
      build_line();
      send_line();
    end
  endtask

  // drop valid and wait for the result queue to drain
  task automatic settle();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic configure(input logic colour_on, input logic [MAXC_W-1:0] cols,
                           input rx_mode_t mode, input logic calm);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_COLOUR_EN;
    cfg_data  <= {(CFG_DATA_W-1)'($urandom), colour_on};
    @(posedge clk);
    cfg_index <= CFG_MAX_COLS;
    cfg_data  <= CFG_DATA_W'(cols);
    @(posedge clk);
    cfg_we      <= 1'b0;
    rx_mode     <= mode;
    sender_calm = calm;
    settings_run++;
    @(posedge clk);
    sent_in_phase = 0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    rx_mode <= STALL_LIGHT;
    @(posedge clk);

    // every attribute, a full colour code, a bare comma before text, UTF-8,
    // dropped control bytes and a comma ending the line
    line_bytes = '{BYTE_BOLD, 8'h42, BYTE_UNDERLINE, BYTE_ITALIC, BYTE_REVERSE, 8'h78,
                   BYTE_RESET, BYTE_COLOUR, 8'h31, 8'h32, BYTE_COMMA, 8'h33, 8'h34,
                   8'h79, BYTE_COLOUR, 8'h37, BYTE_COMMA, 8'h7A, 8'hE2, 8'h82, 8'hAC,
                   8'hFF, 8'h00, BYTE_COLOUR, BYTE_COMMA};
    send_line();
    // a line with nothing shown
    line_bytes = '{BYTE_BOLD};
    send_line();

    configure(1'b1, 10'd80, STALL_LIGHT, 1'b0);
    run_lines(120);
    configure(1'b0, 10'd5, STALL_HEAVY, 1'b0);
    run_lines(110);
    configure(1'b1, 10'd0, STALL_NONE, 1'b1);
    run_lines(60);
    configure(1'b1, 10'd1023, STALL_PRESSURE, 1'b1);
    run_lines(150);
    configure(1'b0, 10'd12, STALL_LIGHT, 1'b0);
    run_lines(110);
    configure(1'b1, 10'd3, STALL_HEAVY, 1'b0);
    run_lines(110);

    byte_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);

    $display("Covered %0d byte requests and %0d results over %0d register settings,",
             requests_taken, results_checked, settings_run);
    $display("with colour on and off, column limits from 0 to 1023 and a long result hold-off.");
    if (mismatches == 0 && results_due == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
